@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Depends on nothing; each use expects a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ITDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ITDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/itda_pkg.sv @@
// Shared types and constants for the integer to decimal text converter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package itda_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 6;
  localparam int OUT_TDATA_W = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int RADIX       = 10;
  localparam int COUNT_W     = $clog2(VALUE_W);
  localparam int REM_W       = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef logic [3:0] digit_t;

  localparam digit_t DABBLE_MIN = 4'(RADIX / 2);
  localparam digit_t DABBLE_ADD = 4'(16 / 2 - RADIX / 2);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     bit_in;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/itda_digit_cell.sv @@
// One decimal digit cell of the conversion chain: add-3 and shift, move, clear or hold.
// Depends on itda_pkg.
`default_nettype none

module itda_digit_cell (
  input  wire                 clk,
  input  itda_pkg::cell_op_t  op,
  input  wire                 bit_in,
  input  itda_pkg::digit_t    digit_in,
  output itda_pkg::digit_t    digit,
  output logic                carry_out
);
  import itda_pkg::*;

  digit_t adj;

  always_comb begin
    adj       = (digit >= DABBLE_MIN) ? digit + DABBLE_ADD : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:   digit <= digit;
      CELL_CLEAR:  digit <= '0;
      CELL_DABBLE: digit <= {adj[2:0], bit_in};
      CELL_SHIFT:  digit <= digit_in;
      default:     digit <= digit;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/itda_digit_chain.sv @@
// Row of digit cells; the least significant cell takes the serial bit.
// Depends on itda_pkg and itda_digit_cell.
`default_nettype none

module itda_digit_chain (
  input  wire                    clk,
  input  itda_pkg::chain_ctrl_t  ctrl,
  output itda_pkg::digit_t       top_digit
);
  import itda_pkg::*;

  digit_t                  digits [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]   carry;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic   cell_bit;
    digit_t cell_din;

    if (i == 0) begin : g_first
      assign cell_bit = ctrl.bit_in;
      assign cell_din = '0;
    end else begin : g_rest
      assign cell_bit = carry[i-1];
      assign cell_din = digits[i-1];
    end

    itda_digit_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .bit_in    (cell_bit),
      .digit_in  (cell_din),
      .digit     (digits[i]),
      .carry_out (carry[i])
    );
  end

  assign top_digit = digits[NUM_DIGITS-1];

endmodule

`default_nettype wire

@@ hdl/int_to_decimal_ascii.sv @@
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Depends on itda_pkg and itda_digit_chain (which uses itda_digit_cell).
//
// Input channel s_axis_*: one item is one signed 32-bit integer in s_axis_tdata.
// Output channel m_axis_*: one item per character, most significant first;
//   m_axis_tdata[5:0] is the ASCII code (45 minus sign, 48..57 digits), the
//   upper bits are zero; m_axis_tlast marks the final character of a number.
//   Leading zeros are dropped, zero gives '0', and the most negative value
//   gives "-2147483648".
// Timing: an accepted number makes a 32-step pass through the double-dabble row
//   of ten digit cells (one magnitude bit per cycle), then drops its leading
//   zeros (up to 9) and emits the sign, if any, and the digits through the
//   output register. All characters of a number must be loaded into the output
//   register before the next number can be accepted; s_axis_tready is high only
//   while idle and out of reset, and the final character may still wait in the
//   output register.
// Reset and stall: rst (synchronous, active high) drops any number in flight
//   and empties the output register. A stalled receiver (m_axis_tready low)
//   holds the character and, while emitting, freezes the digit row until it is taken.
`default_nettype none

module int_to_decimal_ascii (
  input  wire         clk,
  input  wire         rst,
  // s_axis_tdata: value[31:0]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,
  // m_axis_tdata: char_code[5:0], zero[7:6]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import itda_pkg::*;

  // Control state.
  state_t              state, state_next;
  logic                out_valid;

  // Working data.
  logic [VALUE_W-1:0]  mag;
  logic                negative;
  logic [COUNT_W-1:0]  count;
  logic [REM_W-1:0]    remaining;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;

  // Decisions of the sequencer for this cycle.
  chain_ctrl_t         ctrl;
  digit_t              top_digit;
  logic                accept;
  logic                load_ok;
  logic                load_out;
  logic [CHAR_W-1:0]   char_next;
  logic                last_next;

  itda_digit_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit)
  );

  assign load_ok = !out_valid || m_axis_tready;
  assign accept  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: convert, drop leading zeros, then emit sign and digits.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ctrl.op       = CELL_HOLD;
    ctrl.bit_in   = mag[VALUE_W-1];
    load_out      = 1'b0;
    char_next     = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
    last_next     = (remaining == REM_W'(1));

    unique case (state)
      ST_IDLE: begin
        // Take no item while reset is held.
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          ctrl.op    = CELL_CLEAR;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.op = CELL_DABBLE;
        if (count == COUNT_W'(VALUE_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros but always keep the last digit.
        if (top_digit == '0 && remaining > REM_W'(1)) begin
          ctrl.op = CELL_SHIFT;
        end else begin
          state_next = negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        char_next = CHAR_MINUS;
        last_next = 1'b0;
        if (load_ok) begin
          load_out   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          load_out = 1'b1;
          ctrl.op  = CELL_SHIFT;
          if (last_next) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Working registers: magnitude shifter, sign flag, step counter, digits left.
  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= s_axis_tdata[VALUE_W-1];
      mag      <= s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
      count    <= '0;
    end else if (state == ST_CONV) begin
      mag   <= {mag[VALUE_W-2:0], 1'b0};
      count <= count + COUNT_W'(1);
    end
    if (state == ST_CONV) begin
      remaining <= REM_W'(NUM_DIGITS);
    end else if (ctrl.op == CELL_SHIFT) begin
      remaining <= remaining - REM_W'(1);
    end
  end

  // Output register: hold the character until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char <= char_next;
      out_last <= last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

@@ hdl/itda_checker.sv @@
// Port-level checker for int_to_decimal_ascii, attached by the bind below.
// Depends on itda_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module itda_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [31:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast
);
  import itda_pkg::*;

  logic               s_fire;
  logic               m_fire;
  logic [CHAR_W-1:0]  code;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign code   = m_axis_tdata[CHAR_W-1:0];

  // A stalled character holds.
  `ITDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "stalled output character changed")

  // Only a minus sign or a digit leaves, with the pad bits clear.
  `ITDA_ASSERT_SAME(a_code_range, m_axis_tvalid,
    m_axis_tdata[OUT_TDATA_W-1:CHAR_W] == '0 &&
    (code == CHAR_MINUS || (code >= CHAR_ZERO && code <= CHAR_NINE)),
    "output character is neither minus sign nor digit")

  // The sign is never the final character.
  `ITDA_ASSERT_SAME(a_minus_not_last, m_axis_tvalid && code == CHAR_MINUS,
    !m_axis_tlast, "minus sign flagged as last")

  // A new number is not taken right after one was accepted.
  `ITDA_ASSERT_NEXT(a_one_at_a_time, s_fire, !s_axis_tready,
    "input ready right after acceptance")

  // While a non-final character is handed over, no new number is taken.
  `ITDA_ASSERT_SAME(a_no_accept_mid_number, m_fire && !m_axis_tlast, !s_axis_tready,
    "input ready while a number is being emitted")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

`default_nettype wire
